// File: rtl/blsc_pkg.sv
// Package for the budgeted LRU slot cache: sizes, word types and sequencer states.
// No dependencies; imported by rtl/budgeted_lru_slot_cache.sv.
package blsc_pkg;

  localparam int SLOTS        = 9;
  localparam int KEY_BITS     = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int SLOT_FIELD_W = 4;
  localparam int KEY_FIELD_W  = 32;
  localparam int BYTES_W      = 48;
  localparam int STAMP_W      = 32;
  localparam int MASK_W       = 9;

  localparam logic FUNC_REQUEST   = 1'b0;
  localparam logic FUNC_UNPIN_ALL = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [KEY_FIELD_W-1:0]  model_key;
    logic [BYTES_W-1:0]      estimate_bytes;
    logic [BYTES_W-1:0]      resident_bytes;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic               replaced;
    logic [MASK_W-1:0]  evicted_mask;
    logic               cannot_fit;
    logic [BYTES_W-1:0] used_bytes;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIT,
    ST_SCAN,
    ST_EVICT,
    ST_LOAD,
    ST_DONE
  } state_e;

endpackage

// File: rtl/budgeted_lru_slot_cache.sv
// Top level of the budgeted LRU slot cache: slot table, scan sequencer, output register.
// Depends on rtl/blsc_pkg.sv.
//
// One word in, one word out. A hit passes through the check and done states after
// acceptance, an unpin-all or out-of-range word goes straight to the done state; a miss
// passes through fit and load, plus a scan and an evict pass for each evicted slot and for
// a pass that runs out of victims. The single stamp comparator walks the slot table one
// entry a cycle to find the least-recently-used unpinned victim. The input is stalled while
// a word is in work; a finished result waits in the output register. A byte budget of zero
// disables eviction.
module budgeted_lru_slot_cache (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  blsc_pkg::in_t          in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output blsc_pkg::out_t         out_data_o,
  input  logic                   cfg_we_i,
  input  logic [blsc_pkg::BYTES_W-1:0] cfg_data_i
);
  import blsc_pkg::*;

  localparam int EXT_W = (SLOTS > MASK_W) ? SLOTS : MASK_W;

  state_e state_q, state_d;

  logic [SLOTS-1:0]    loaded_q, loaded_d;
  logic [SLOTS-1:0]    pinned_q, pinned_d;
  logic [STAMP_W-1:0]  stamp_q [SLOTS];
  logic [STAMP_W-1:0]  stamp_d [SLOTS];
  logic [BYTES_W-1:0]  size_q  [SLOTS];
  logic [BYTES_W-1:0]  size_d  [SLOTS];
  logic [KEY_BITS-1:0] key_q   [SLOTS];

  logic [BYTES_W-1:0]  used_q, used_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic [BYTES_W-1:0]  budget_q;

  logic [SLOT_W-1:0]   req_q, req_d;
  logic [KEY_BITS-1:0] rkey_q, rkey_d;
  logic [BYTES_W-1:0]  est_q, est_d;
  logic [BYTES_W-1:0]  res_q, res_d;
  logic                phase_q, phase_d;

  logic [SLOT_W-1:0]   scan_q, scan_d;
  logic                vic_valid_q, vic_valid_d;
  logic [SLOT_W-1:0]   vic_idx_q, vic_idx_d;
  logic [STAMP_W-1:0]  vic_stamp_q, vic_stamp_d;
  logic [BYTES_W-1:0]  vic_size_q, vic_size_d;

  logic                hit_q, hit_d;
  logic                repl_q, repl_d;
  logic [SLOTS-1:0]    ev_q, ev_d;
  logic                nofit_q, nofit_d;

  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                key_we;
  logic                in_accept;
  logic                in_range;
  logic [SLOT_W-1:0]   rd_idx;
  logic                rd_loaded;
  logic                rd_pinned;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [BYTES_W-1:0]  rd_size;
  logic [KEY_BITS-1:0] rd_key;
  logic                key_match;
  logic [BYTES_W-1:0]  sub_sz;
  logic [BYTES_W-1:0]  used_rel;
  logic [BYTES_W-1:0]  incoming;
  logic [BYTES_W:0]    need_sum;
  logic [BYTES_W:0]    load_sum;
  logic                over;
  logic                cand;
  logic                better;
  logic                scan_last;
  logic                out_free;
  logic [EXT_W-1:0]    ev_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_range  = (int'(in_data_i.slot) < SLOTS);
  assign out_free  = !out_valid_q || !out_stall_i;

  // single read port into the slot table
  assign rd_idx    = (state_q == ST_SCAN) ? scan_q : req_q;
  assign rd_loaded = loaded_q[rd_idx];
  assign rd_pinned = pinned_q[rd_idx];
  assign rd_stamp  = stamp_q[rd_idx];
  assign rd_size   = size_q[rd_idx];
  assign rd_key    = key_q[rd_idx];
  assign key_match = rd_loaded && (rd_key == rkey_q);

  assign sub_sz   = (state_q == ST_EVICT) ? vic_size_q : rd_size;
  assign used_rel = (used_q >= sub_sz) ? (used_q - sub_sz) : '0;

  assign incoming = phase_q ? '0 : est_q;
  assign need_sum = {1'b0, used_q} + {1'b0, incoming};
  assign over     = (budget_q != '0) && (need_sum > {1'b0, budget_q});
  assign load_sum = {1'b0, used_q} + {1'b0, res_q};

  assign cand      = rd_loaded && !rd_pinned && (scan_q != req_q);
  assign better    = !vic_valid_q || (rd_stamp < vic_stamp_q);
  assign scan_last = (scan_q == SLOT_W'(SLOTS - 1));

  assign ev_ext = EXT_W'(ev_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.func == FUNC_REQUEST && in_range) state_d = ST_CHECK;
          else state_d = ST_DONE;
        end
      end
      ST_CHECK: begin
        state_d = key_match ? ST_DONE : ST_FIT;
      end
      ST_FIT: begin
        if (over) state_d = ST_SCAN;
        else state_d = phase_q ? ST_DONE : ST_LOAD;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_EVICT;
      end
      ST_EVICT: begin
        if (vic_valid_q) state_d = ST_FIT;
        else state_d = phase_q ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_FIT;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    loaded_d    = loaded_q;
    pinned_d    = pinned_q;
    stamp_d     = stamp_q;
    size_d      = size_q;
    used_d      = used_q;
    clock_d     = clock_q;
    req_d       = req_q;
    rkey_d      = rkey_q;
    est_d       = est_q;
    res_d       = res_q;
    phase_d     = phase_q;
    scan_d      = scan_q;
    vic_valid_d = vic_valid_q;
    vic_idx_d   = vic_idx_q;
    vic_stamp_d = vic_stamp_q;
    vic_size_d  = vic_size_q;
    hit_d       = hit_q;
    repl_d      = repl_q;
    ev_d        = ev_q;
    nofit_d     = nofit_q;
    key_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          req_d   = SLOT_W'(in_data_i.slot);
          rkey_d  = KEY_BITS'(in_data_i.model_key);
          est_d   = in_data_i.estimate_bytes;
          res_d   = in_data_i.resident_bytes;
          phase_d = 1'b0;
          hit_d   = 1'b0;
          repl_d  = 1'b0;
          ev_d    = '0;
          nofit_d = 1'b0;
          if (in_data_i.func == FUNC_UNPIN_ALL) pinned_d = '0;
        end
      end
      ST_CHECK: begin
        if (key_match) begin
          hit_d           = 1'b1;
          clock_d         = clock_q + STAMP_W'(1);
          stamp_d[req_q]  = clock_q + STAMP_W'(1);
          pinned_d[req_q] = 1'b1;
        end else if (rd_loaded) begin
          repl_d          = 1'b1;
          used_d          = used_rel;
          loaded_d[req_q] = 1'b0;
          pinned_d[req_q] = 1'b0;
          stamp_d[req_q]  = '0;
          size_d[req_q]   = '0;
        end
      end
      ST_FIT: begin
        scan_d      = '0;
        vic_valid_d = 1'b0;
      end
      ST_SCAN: begin
        if (cand && better) begin
          vic_valid_d = 1'b1;
          vic_idx_d   = scan_q;
          vic_stamp_d = rd_stamp;
          vic_size_d  = rd_size;
        end
        if (!scan_last) scan_d = scan_q + SLOT_W'(1);
      end
      ST_EVICT: begin
        if (vic_valid_q) begin
          used_d              = used_rel;
          loaded_d[vic_idx_q] = 1'b0;
          pinned_d[vic_idx_q] = 1'b0;
          stamp_d[vic_idx_q]  = '0;
          size_d[vic_idx_q]   = '0;
          ev_d[vic_idx_q]     = 1'b1;
        end else begin
          nofit_d = 1'b1;
        end
      end
      ST_LOAD: begin
        key_we          = 1'b1;
        size_d[req_q]   = res_q;
        used_d          = load_sum[BYTES_W] ? '1 : load_sum[BYTES_W-1:0];
        loaded_d[req_q] = 1'b1;
        clock_d         = clock_q + STAMP_W'(1);
        stamp_d[req_q]  = clock_q + STAMP_W'(1);
        pinned_d[req_q] = 1'b1;
        phase_d         = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.hit          = hit_q;
          out_d.replaced     = repl_q;
          out_d.evicted_mask = ev_ext[MASK_W-1:0];
          out_d.cannot_fit   = nofit_q;
          out_d.used_bytes   = used_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      pinned_q    <= '0;
      used_q      <= '0;
      clock_q     <= '0;
      budget_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        stamp_q[i] <= '0;
        size_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      pinned_q    <= pinned_d;
      used_q      <= used_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
      stamp_q     <= stamp_d;
      size_q      <= size_d;
      if (cfg_we_i) budget_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rkey_q      <= rkey_d;
    est_q       <= est_d;
    res_q       <= res_d;
    phase_q     <= phase_d;
    scan_q      <= scan_d;
    vic_valid_q <= vic_valid_d;
    vic_idx_q   <= vic_idx_d;
    vic_stamp_q <= vic_stamp_d;
    vic_size_q  <= vic_size_d;
    hit_q       <= hit_d;
    repl_q      <= repl_d;
    ev_q        <= ev_d;
    nofit_q     <= nofit_d;
    out_q       <= out_d;
    if (key_we) key_q[req_q] <= rkey_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rose_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result word appeared outside the done state");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |->
      (!out_data_o.replaced && out_data_o.evicted_mask == '0 && !out_data_o.cannot_fit))
    else $error("hit word reports replacement or eviction");

  a_victim_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT && vic_valid_q) |->
      (vic_idx_q != req_q && loaded_q[vic_idx_q] && !pinned_q[vic_idx_q]))
    else $error("victim is the requested slot, unloaded or pinned");

  a_no_evict_unlimited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (budget_q != '0))
    else $error("victim scan with unlimited budget");

endmodule
